// ===== hw/rtl/slis_pkg.sv =====
// Shared types and constants for the sorted leaf insert/split block.
package slis_pkg;

  localparam int KEY_W    = 32;
  localparam int PAGE_W   = 32;
  localparam int STATUS_W = 2;
  localparam int CFG_W    = 32;

  // Command codes carried in the input tuser
  localparam logic CMD_CLEAR  = 1'b0;
  localparam logic CMD_INSERT = 1'b1;

  // Result status codes carried in the output tuser
  localparam logic [STATUS_W-1:0] STATUS_CLEAR  = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_INSERT = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_SPLIT  = 2'd2;

  // Register index of the page marker
  localparam logic REG_MARKER = 1'b0;

  localparam logic [PAGE_W-1:0] MARKER_RESET = 32'hFFFF_FFFF;

  // Per-cell control from the sequencer
  typedef struct packed {
    logic ins;       // insert the new pair this cycle
    logic shift;     // take the right neighbor's pair (split readout)
    logic occupied;  // cell index is below the entry count
    logic at_count;  // cell index equals the entry count
  } slis_cell_ctrl_t;

endpackage

// ===== hw/rtl/sorted_leaf_insert_split_top.sv =====
// Top level of the sorted leaf insert/split block: cell row, sequencer, stream and APB ports.
//
// Holds one B+ tree leaf of up to NODE_KEYS sorted signed keys with row ids.
// Input items arrive on s_t*: tuser is the command (clear or insert), tdata the
// key, row id and page ids. Results leave on m_t*: tuser is the status, tlast
// marks the final result of an input item, tdata carries the result fields.
// A clear or a non-full insert is applied on acceptance and gives one result
// in the cycle after acceptance; the next item is taken as soon as the
// output register is free, so these sustain one item per cycle while results are taken.
// An insert into a full node sorts the pair into the row, using the overflow
// cell at the top, in the same cycle, then streams the right half (NODE_KEYS+1
// minus the kept (NODE_KEYS+2)/2 pairs) out of cell (NODE_KEYS+2)/2, one result
// per cycle while the receiver takes them, by shifting the upper cells down;
// input is held off until the last result is loaded.
// When the receiver stalls, the output register holds its result and the row
// stops shifting; no result is lost. Reset empties the node and sets the page
// id, link and page marker to all ones. APB writes with paddr[2] low set the
// marker; the user must write it only while idle, the block does not enforce it.
module sorted_leaf_insert_split_top
  import slis_pkg::*;
#(
  parameter int NODE_KEYS   = 32,
  parameter int ROW_ID_BITS = 48
) (
  input  logic             clk,
  input  logic             rst,
  // APB register port
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [2:0]       paddr,
  input  logic [CFG_W-1:0] pwdata,
  output logic [CFG_W-1:0] prdata,
  output logic             pready,
  // Input items
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic             s_tuser,   // command
  // key, row_id, page_id, new_page_id, link_in (zero padded to bytes)
  input  logic [((KEY_W+ROW_ID_BITS+3*PAGE_W+7)/8)*8-1:0] s_tdata,
  // Results
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [STATUS_W-1:0] m_tuser, // status
  output logic             m_tlast,
  // out_key, out_row_id, kept_count, node_page, right_page, right_link,
  // separator_key (zero padded to bytes)
  output logic [((KEY_W+ROW_ID_BITS+$clog2(NODE_KEYS+1)+4*PAGE_W+7)/8)*8-1:0] m_tdata
);

  localparam int CW     = $clog2(NODE_KEYS + 1);
  localparam int IN_W   = KEY_W + ROW_ID_BITS + 3 * PAGE_W;
  localparam int OUT_W  = KEY_W + ROW_ID_BITS + CW + 4 * PAGE_W;
  localparam int OUT_TW = ((OUT_W + 7) / 8) * 8;
  localparam int LEFT   = (NODE_KEYS + 2) / 2;
  localparam int RIGHT  = NODE_KEYS + 1 - LEFT;

  localparam logic [CW-1:0] FULL_CNT  = CW'(NODE_KEYS);
  localparam logic [CW-1:0] LEFT_CNT  = CW'(LEFT);
  localparam logic [CW-1:0] RIGHT_CNT = CW'(RIGHT);

  localparam logic S_IDLE  = 1'b0;
  localparam logic S_SPLIT = 1'b1;

  // Unpack input item
  logic signed [KEY_W-1:0]       in_key;
  logic        [ROW_ID_BITS-1:0] in_rid;
  logic        [PAGE_W-1:0]      in_page;
  logic        [PAGE_W-1:0]      in_new_page;
  logic        [PAGE_W-1:0]      in_link;
  logic        [IN_W-1:0]        in_bits;

  assign in_bits = s_tdata[IN_W-1:0];
  assign {in_link, in_new_page, in_page, in_rid, in_key} = in_bits;

  // Block state
  logic              state;
  logic [CW-1:0]     entry_count;
  logic [PAGE_W-1:0] own_page;
  logic [PAGE_W-1:0] own_page_next;
  logic [PAGE_W-1:0] leaf_link;
  logic [CFG_W-1:0]  marker;
  logic [PAGE_W-1:0] split_page;
  logic [PAGE_W-1:0] split_link;
  logic [CW-1:0]     remaining;

  // Output register
  logic signed [KEY_W-1:0]       out_key;
  logic        [ROW_ID_BITS-1:0] out_rid;
  logic        [CW-1:0]          out_kept;
  logic        [PAGE_W-1:0]      out_node_page;
  logic        [PAGE_W-1:0]      out_right_page;
  logic        [PAGE_W-1:0]      out_right_next;
  logic signed [KEY_W-1:0]       out_sep;
  logic        [STATUS_W-1:0]    out_status;
  logic                          out_last;
  logic                          out_valid;

  logic out_free;
  logic s_fire;
  logic ins_fire;
  logic split_start;
  logic emit;
  logic cfg_write;
  logic cfg_idx;

  // Cell row with one overflow cell at the top
  logic signed [KEY_W-1:0]       ck   [NODE_KEYS+1];
  logic        [ROW_ID_BITS-1:0] crid [NODE_KEYS+1];
  logic                          cgt  [NODE_KEYS+1];
  slis_cell_ctrl_t               cctl [NODE_KEYS+1];

  assign out_free    = !out_valid || m_tready;
  assign s_tready    = !rst && (state == S_IDLE) && out_free;
  assign s_fire      = s_tvalid && s_tready;
  assign ins_fire    = s_fire && (s_tuser == CMD_INSERT);
  assign split_start = ins_fire && (entry_count == FULL_CNT);
  assign emit        = (state == S_SPLIT) && out_free;

  genvar gi;
  generate
    for (gi = 0; gi <= NODE_KEYS; gi++) begin : g_cell
      logic signed [KEY_W-1:0]       lk;
      logic        [ROW_ID_BITS-1:0] lr;
      logic                          lg;
      logic signed [KEY_W-1:0]       rk;
      logic        [ROW_ID_BITS-1:0] rr;

      if (gi == 0) begin : g_first
        assign lk = '0;
        assign lr = '0;
        assign lg = 1'b0;
      end else begin : g_mid
        assign lk = ck[gi-1];
        assign lr = crid[gi-1];
        assign lg = cgt[gi-1];
      end

      if (gi == NODE_KEYS) begin : g_last
        assign rk = '0;
        assign rr = '0;
      end else begin : g_up
        assign rk = ck[gi+1];
        assign rr = crid[gi+1];
      end

      assign cctl[gi].ins      = ins_fire;
      assign cctl[gi].shift    = (gi >= LEFT) ? emit : 1'b0;
      assign cctl[gi].occupied = CW'(gi) < entry_count;
      assign cctl[gi].at_count = CW'(gi) == entry_count;

      slis_cell #(
        .RID_W (ROW_ID_BITS)
      ) u_cell (
        .clk       (clk),
        .ctrl      (cctl[gi]),
        .new_key   (in_key),
        .new_rid   (in_rid),
        .left_key  (lk),
        .left_rid  (lr),
        .left_gt   (lg),
        .right_key (rk),
        .right_rid (rr),
        .key       (ck[gi]),
        .rid       (crid[gi]),
        .gt        (cgt[gi])
      );
    end
  endgenerate

  // Page id taken by the first insert into an empty, unassigned node
  always_comb begin
    own_page_next = own_page;
    if (ins_fire && (entry_count == '0) && (own_page == marker)) begin
      own_page_next = in_page;
    end
  end

  // Sequencer and node bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      entry_count <= '0;
      own_page    <= MARKER_RESET;
      leaf_link   <= MARKER_RESET;
      remaining   <= '0;
      out_valid   <= 1'b0;
    end else begin
      // Hold the result until taken; load one per clear or non-full insert, one per readout step
      out_valid <= (out_valid && !m_tready) || (s_fire && !split_start) || emit;
      if (s_fire) begin
        own_page <= own_page_next;
        if (s_tuser == CMD_CLEAR) begin
          entry_count <= '0;
          leaf_link   <= in_link;
        end else if (split_start) begin
          entry_count <= LEFT_CNT;
          leaf_link   <= in_new_page;
          remaining   <= RIGHT_CNT;
          state       <= S_SPLIT;
        end else begin
          entry_count <= entry_count + CW'(1);
        end
      end
      if (emit) begin
        remaining <= remaining - CW'(1);
        if (remaining == CW'(1)) begin
          state <= S_IDLE;
        end
      end
    end
  end

  // Split context: new page and inherited link
  always_ff @(posedge clk) begin
    if (split_start) begin
      split_page <= in_new_page;
      split_link <= leaf_link;
    end
  end

  // Load result payload
  always_ff @(posedge clk) begin
    if (s_fire && !split_start) begin
      out_key        <= '0;
      out_rid        <= '0;
      out_right_page <= '0;
      out_right_next <= '0;
      out_sep        <= '0;
      out_last       <= 1'b1;
      out_node_page  <= own_page_next;
      if (s_tuser == CMD_CLEAR) begin
        out_status <= STATUS_CLEAR;
        out_kept   <= '0;
      end else begin
        out_status <= STATUS_INSERT;
        out_kept   <= entry_count + CW'(1);
      end
    end else if (emit) begin
      out_status     <= STATUS_SPLIT;
      out_key        <= ck[LEFT];
      out_rid        <= crid[LEFT];
      out_kept       <= entry_count;
      out_node_page  <= own_page;
      out_right_page <= split_page;
      out_right_next <= split_link;
      out_last       <= (remaining == CW'(1));
      if (remaining == RIGHT_CNT) begin
        out_sep <= ck[LEFT];
      end
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_status;
  assign m_tlast  = out_last;
  assign m_tdata  = OUT_TW'({out_sep, out_right_next, out_right_page, out_node_page,
                             out_kept, out_rid, out_key});

  // Register port
  assign pready    = 1'b1;
  assign cfg_idx   = paddr[2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      marker <= MARKER_RESET;
    end else if (cfg_write && (cfg_idx == REG_MARKER)) begin
      marker <= pwdata;
    end
  end

  assign prdata = (cfg_idx == REG_MARKER) ? marker : '0;

`ifndef NO_ASSERTIONS
  // Entry count never exceeds node capacity
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= FULL_CNT)
    else $error("entry count above capacity");

  // Insert into a full node keeps the left half and starts readout
  a_split_enter: assert property (@(posedge clk) disable iff (rst)
    split_start |=> (state == S_SPLIT) && (entry_count == LEFT_CNT)
                    && (remaining == RIGHT_CNT))
    else $error("split did not start readout");

  // Input is held off for the whole readout
  a_split_block: assert property (@(posedge clk) disable iff (rst)
    (state == S_SPLIT) |-> !s_tready)
    else $error("input accepted during split readout");

  // Lowest two keys stay in order
  a_sorted: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) && (entry_count >= CW'(2)) |-> !(ck[0] > ck[1]))
    else $error("leaf keys out of order");
`endif

endmodule

// ===== hw/rtl/slis_cell.sv =====
// One slot of the leaf: holds a key and row id, compares and shifts with its neighbors.
module slis_cell
  import slis_pkg::*;
#(
  parameter int RID_W = 48
) (
  input  logic                    clk,
  input  slis_cell_ctrl_t         ctrl,
  input  logic signed [KEY_W-1:0] new_key,
  input  logic        [RID_W-1:0] new_rid,
  input  logic signed [KEY_W-1:0] left_key,
  input  logic        [RID_W-1:0] left_rid,
  input  logic                    left_gt,
  input  logic signed [KEY_W-1:0] right_key,
  input  logic        [RID_W-1:0] right_rid,
  output logic signed [KEY_W-1:0] key,
  output logic        [RID_W-1:0] rid,
  output logic                    gt
);

  // Valid stored key strictly greater than the incoming key
  assign gt = ctrl.occupied && (key > new_key);

  // Shift up from the left, drop in the new pair, or shift down for readout
  always_ff @(posedge clk) begin
    if (ctrl.ins) begin
      if (left_gt) begin
        key <= left_key;
        rid <= left_rid;
      end else if (gt || ctrl.at_count) begin
        key <= new_key;
        rid <= new_rid;
      end
    end else if (ctrl.shift) begin
      key <= right_key;
      rid <= right_rid;
    end
  end

endmodule
